// ===== rtl/rrob_pkg.sv =====
// Shared constants, types and step functions for the rounded rectangle blend pipeline.
package rrob_pkg;

    localparam int CANVAS_WIDTH  = 360;
    localparam int CANVAS_HEIGHT = 110;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // (x*RECIP_255)>>23 for x below 2^24 is the floor of x/255 or one more than it.
    localparam logic [15:0] RECIP_255 = 16'd32897;
    localparam int RECIP_SHIFT = 23;

    localparam int SQRT_STAGES = 8;
    localparam int DIV_STAGES  = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RECT_LEFT   = 3'd0,
        REG_RECT_TOP    = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_RADIUS      = 3'd4,
        REG_FILL_COLOR  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [30:0] rem;
        logic [15:0] root;
    } sq_t;

    typedef struct packed {
        logic [16:0] rem;
        logic [7:0]  den;
        logic [7:0]  quo;
        logic        ovf;
    } div_t;

    // One bit of the digit-by-digit square root; rem holds n - root^2.
    function automatic sq_t sqrt_step(input sq_t s, input int unsigned i);
        logic [32:0] trial;
        sq_t         o;
        o = s;
        trial = (33'(s.root) << (i + 1)) + (33'(1) << (2 * i));
        if (33'(s.rem) >= trial) begin
            o.rem  = s.rem - trial[30:0];
            o.root = s.root | (16'(1) << i);
        end
        return o;
    endfunction

    // One bit of restoring division.
    function automatic div_t div_step(input div_t s, input int unsigned i);
        logic [16:0] trial;
        div_t        o;
        o = s;
        trial = 17'(s.den) << i;
        if (s.rem >= trial) begin
            o.rem = s.rem - trial;
            o.quo = s.quo | (8'(1) << i);
        end
        return o;
    endfunction

endpackage

// ===== rtl/rrob_isqrt.sv =====
// Pipelined integer square root of d2*65536, two result bits per stage.
module rrob_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [14:0] d2,
    output logic [15:0] root
);
    import rrob_pkg::*;

    sq_t stage_reg [SQRT_STAGES];
    sq_t stage_next [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        sq_t src;
        if (k == 0) begin : g_first
            assign src = '{rem: {d2, 16'd0}, root: 16'd0};
        end else begin : g_rest
            assign src = stage_reg[k-1];
        end
        assign stage_next[k] = sqrt_step(sqrt_step(src, 15 - 2 * k), 14 - 2 * k);

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign root = stage_reg[SQRT_STAGES-1].root;

endmodule

// ===== rtl/rrob_div.sv =====
// Pipelined 17 by 8 bit divider with a quotient that saturates at 255.
module rrob_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [16:0] num,
    input  logic [7:0]  den,
    output logic [7:0]  quo
);
    import rrob_pkg::*;

    div_t stage_reg [DIV_STAGES];
    div_t stage_next [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        div_t src;
        if (k == 0) begin : g_first
            // A quotient of 256 or more cannot fit and saturates.
            assign src = '{rem: num, den: den, quo: 8'd0, ovf: (num >= {1'b0, den, 8'd0})};
        end else begin : g_rest
            assign src = stage_reg[k-1];
        end
        assign stage_next[k] = div_step(div_step(src, 7 - 2 * k), 6 - 2 * k);

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign quo = stage_reg[DIV_STAGES-1].ovf ? 8'hFF : stage_reg[DIV_STAGES-1].quo;

endmodule

// ===== rtl/rounded_rect_over_blend_pixel.sv =====
// Top level of the anti-aliased rounded rectangle fill and over-blend pipeline.
//
// Each input beat carries one pixel coordinate and the canvas pixel found there,
// and yields exactly one output beat, in order: the new pixel and a write enable.
// The pipeline takes one beat per clock while the output is not stalled and holds
// 20 register stages from the input to the output register. The depth is set by
// the digit-by-digit square root (eight stages, two root bits each) and the
// restoring channel divider (four stages); all stages advance together and
// freeze together when the output beat is not taken, so the input is ready
// whenever the output register is empty or being drained. Registers are to be
// written through the plain write port only while no beat is in flight; the
// block itself does not enforce this.
module rounded_rect_over_blend_pixel (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [8:0] pixel_x, [16:9] pixel_y, [48:17] dest_pixel, rest zero
    input  logic [rrob_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] blended_pixel, [32] write_enable, rest zero
    output logic [rrob_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [rrob_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rrob_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import rrob_pkg::*;

    typedef struct packed {
        logic        valid;
        logic        write;
        logic        edge_band;
        logic [31:0] dest;
    } side_t;

    typedef struct packed {
        logic        valid;
        logic        write;
        logic [31:0] dest;
    } bside_t;

    // Configuration registers.
    logic [8:0]  left_reg;
    logic [7:0]  top_reg;
    logic [9:0]  width_reg;
    logic [8:0]  height_reg;
    logic [6:0]  radius_reg;
    logic [31:0] fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            radius_reg <= '0;
            fill_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RECT_LEFT:   left_reg   <= cfg_wr_data[8:0];
                REG_RECT_TOP:    top_reg    <= cfg_wr_data[7:0];
                REG_RECT_WIDTH:  width_reg  <= cfg_wr_data[9:0];
                REG_RECT_HEIGHT: height_reg <= cfg_wr_data[8:0];
                REG_RADIUS:      radius_reg <= cfg_wr_data[6:0];
                REG_FILL_COLOR:  fill_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves as one; it freezes only while a finished
    // beat waits in the output register.
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Stage 1: canvas and rectangle test, corner offsets.
    logic signed [11:0] px, py, lx, ty, rr, lr, lwr, tr, thr;
    logic               inside_next;
    logic [6:0]         dx_next, dy_next;

    always_comb begin
        px  = signed'({3'd0, s_tdata[8:0]});
        py  = signed'({4'd0, s_tdata[16:9]});
        lx  = signed'({3'd0, left_reg});
        ty  = signed'({4'd0, top_reg});
        rr  = signed'({5'd0, radius_reg});
        lr  = lx + rr;
        lwr = lx + signed'({2'd0, width_reg}) - rr;
        tr  = ty + rr;
        thr = ty + signed'({3'd0, height_reg}) - rr;
        inside_next = (px < 12'(CANVAS_WIDTH)) && (py < 12'(CANVAS_HEIGHT))
                   && (px >= lx) && (px < lx + signed'({2'd0, width_reg}))
                   && (py >= ty) && (py < ty + signed'({3'd0, height_reg}));
        // Inside the rectangle the offsets never exceed the radius.
        if (px < lr)        dx_next = 7'(lr - px);
        else if (px >= lwr) dx_next = 7'(px - lwr + 12'sd1);
        else                dx_next = '0;
        if (py < tr)        dy_next = 7'(tr - py);
        else if (py >= thr) dy_next = 7'(py - thr + 12'sd1);
        else                dy_next = '0;
    end

    logic        v1_reg, in1_reg;
    logic [6:0]  dx1_reg, dy1_reg;
    logic [31:0] dest1_reg;

    // Stage 2: squared distance to the corner center and band tests.
    logic [14:0] d2_next;
    logic [13:0] r2, rm2;
    logic [6:0]  rm1;
    logic        corner, skip, edge_next;

    always_comb begin
        d2_next   = 15'(dx1_reg * dx1_reg) + 15'(dy1_reg * dy1_reg);
        rm1       = radius_reg - 7'd1;
        r2        = 14'(radius_reg * radius_reg);
        rm2       = 14'(rm1 * rm1);
        corner    = (dx1_reg != '0) && (dy1_reg != '0);
        skip      = corner && (d2_next > {1'b0, r2});
        edge_next = corner && (radius_reg != '0) && (d2_next > {1'b0, rm2});
    end

    logic [14:0] d2_reg;
    side_t       side2_reg;
    side_t       sq_side_reg [SQRT_STAGES];
    logic [15:0] root;

    rrob_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .d2   (d2_reg),
        .root (root)
    );

    // Stage 11: edge coverage scales the fill alpha.
    logic [15:0] full, diff;
    logic [23:0] cov;
    logic [7:0]  a_next;
    side_t       sq_last;

    always_comb begin
        sq_last = sq_side_reg[SQRT_STAGES-1];
        full    = {2'd0, radius_reg, 7'd0} << 1;
        diff    = (full > root) ? full - root : 16'd0;
        cov     = 24'(fill_reg[31:24] * diff) >> 8;
        if (!sq_last.edge_band) a_next = fill_reg[31:24];
        else if (cov > 24'd255) a_next = 8'hFF;
        else                    a_next = cov[7:0];
    end

    bside_t      b11_reg, b12_reg, b13_reg, b14_reg, b15_reg;
    bside_t      dv_side_reg [DIV_STAGES];
    logic [7:0]  a11_reg, a12_reg, a13_reg;
    logic [15:0] p12_reg, p13_reg;
    logic [15:0] ca12_reg [3];
    logic [15:0] ca13_reg [3];
    logic [15:0] ca14_reg [3];
    logic [23:0] x13_reg [3];
    logic [23:0] x14_reg [3];
    logic [16:0] xe14_reg [3];
    logic [8:0]  pe13_reg;
    logic [7:0]  oa14_reg, oa15_reg;
    logic [16:0] num15_reg [3];
    logic [7:0]  quo [3];

    // Stage 14 and 15 corrections of the reciprocal estimates.
    logic [31:0] pe_full;
    logic [16:0] pe255;
    logic [8:0]  oa_sum;
    logic [16:0] xe_next [3];
    logic [24:0] xe255 [3];
    logic [15:0] q_corr [3];
    logic [39:0] xp [3];

    always_comb begin
        pe_full = 32'(p12_reg * RECIP_255) >> RECIP_SHIFT;
        pe255   = {pe13_reg, 8'd0} - 17'(pe13_reg);
        oa_sum  = {1'b0, a13_reg}
                + ((pe255 > {1'b0, p13_reg}) ? pe13_reg - 9'd1 : pe13_reg);
        for (int k = 0; k < 3; k++) begin
            xp[k]      = 40'(x13_reg[k] * RECIP_255);
            xe_next[k] = xp[k][39:23];
            xe255[k]   = {xe14_reg[k], 8'd0} - 25'(xe14_reg[k]);
            q_corr[k]  = (xe255[k] > {1'b0, x14_reg[k]}) ? 16'(xe14_reg[k] - 17'd1)
                                                         : xe14_reg[k][15:0];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        rrob_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num15_reg[k]),
            .den  (oa15_reg),
            .quo  (quo[k])
        );
    end

    // Output registers.
    logic [31:0] blended_reg;
    logic        wr_reg;

    // The untouched destination pixel is kept beside the divider stages.
    logic [31:0] dest_hold_reg [DIV_STAGES];

    // Valid bits are cleared by reset; the payload travels with them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg          <= 1'b0;
            side2_reg.valid <= 1'b0;
            for (int k = 0; k < SQRT_STAGES; k++) sq_side_reg[k].valid <= 1'b0;
            b11_reg.valid   <= 1'b0;
            b12_reg.valid   <= 1'b0;
            b13_reg.valid   <= 1'b0;
            b14_reg.valid   <= 1'b0;
            b15_reg.valid   <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) dv_side_reg[k].valid <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else if (en) begin
            v1_reg          <= s_tvalid;
            side2_reg.valid <= v1_reg;
            sq_side_reg[0].valid <= side2_reg.valid;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                sq_side_reg[k].valid <= sq_side_reg[k-1].valid;
            end
            b11_reg.valid   <= sq_last.valid;
            b12_reg.valid   <= b11_reg.valid;
            b13_reg.valid   <= b12_reg.valid;
            b14_reg.valid   <= b13_reg.valid;
            b15_reg.valid   <= b14_reg.valid;
            dv_side_reg[0].valid <= b15_reg.valid;
            for (int k = 1; k < DIV_STAGES; k++) begin
                dv_side_reg[k].valid <= dv_side_reg[k-1].valid;
            end
            m_valid_reg     <= dv_side_reg[DIV_STAGES-1].valid;

            in1_reg   <= inside_next;
            dx1_reg   <= dx_next;
            dy1_reg   <= dy_next;
            dest1_reg <= s_tdata[48:17];

            d2_reg              <= d2_next;
            side2_reg.write     <= in1_reg && !skip;
            side2_reg.edge_band <= edge_next;
            side2_reg.dest      <= dest1_reg;

            sq_side_reg[0].write     <= side2_reg.write;
            sq_side_reg[0].edge_band <= side2_reg.edge_band;
            sq_side_reg[0].dest      <= side2_reg.dest;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                sq_side_reg[k].write     <= sq_side_reg[k-1].write;
                sq_side_reg[k].edge_band <= sq_side_reg[k-1].edge_band;
                sq_side_reg[k].dest      <= sq_side_reg[k-1].dest;
            end

            a11_reg       <= a_next;
            b11_reg.write <= sq_last.write;
            b11_reg.dest  <= sq_last.dest;

            // Stage 12: destination weight and fill terms.
            p12_reg       <= 16'(b11_reg.dest[31:24] * (8'd255 - a11_reg));
            a12_reg       <= a11_reg;
            b12_reg.write <= b11_reg.write;
            b12_reg.dest  <= b11_reg.dest;
            for (int k = 0; k < 3; k++) begin
                ca12_reg[k] <= 16'(fill_reg[8*k +: 8] * a11_reg);
            end

            // Stage 13: destination channel products and alpha estimate.
            pe13_reg      <= pe_full[8:0];
            p13_reg       <= p12_reg;
            a13_reg       <= a12_reg;
            b13_reg.write <= b12_reg.write;
            b13_reg.dest  <= b12_reg.dest;
            for (int k = 0; k < 3; k++) begin
                x13_reg[k]  <= 24'(b12_reg.dest[8*k +: 8] * p12_reg);
                ca13_reg[k] <= ca12_reg[k];
            end

            // Stage 14: output alpha and channel quotient estimates.
            oa14_reg      <= oa_sum[7:0];
            b14_reg.write <= b13_reg.write;
            b14_reg.dest  <= b13_reg.dest;
            for (int k = 0; k < 3; k++) begin
                xe14_reg[k] <= xe_next[k];
                x14_reg[k]  <= x13_reg[k];
                ca14_reg[k] <= ca13_reg[k];
            end

            // Stage 15: channel numerators; a zero alpha means no write.
            oa15_reg      <= oa14_reg;
            b15_reg.write <= b14_reg.write && (oa14_reg != '0);
            b15_reg.dest  <= b14_reg.dest;
            for (int k = 0; k < 3; k++) begin
                num15_reg[k] <= 17'(ca14_reg[k]) + 17'(q_corr[k]);
            end

            dv_side_reg[0].write <= b15_reg.write;
            dv_side_reg[0].dest  <= {oa15_reg, b15_reg.dest[23:0]};
            for (int k = 1; k < DIV_STAGES; k++) begin
                dv_side_reg[k].write <= dv_side_reg[k-1].write;
                dv_side_reg[k].dest  <= dv_side_reg[k-1].dest;
            end

            // The alpha byte rode along in the top of dest; restore the
            // original pixel when nothing is written.
            wr_reg <= dv_side_reg[DIV_STAGES-1].write;
            blended_reg <= dv_side_reg[DIV_STAGES-1].write
                ? {dv_side_reg[DIV_STAGES-1].dest[31:24], quo[2], quo[1], quo[0]}
                : dest_hold_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dest_hold_reg[0] <= b15_reg.dest;
            for (int k = 1; k < DIV_STAGES; k++) begin
                dest_hold_reg[k] <= dest_hold_reg[k-1];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, wr_reg, blended_reg};

endmodule

// ===== rtl/rrob_checker.sv =====
// Port-level checks of the rounded rectangle blend pipeline, bound to the top level.
module rrob_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A beat that is not taken keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // An empty output register never blocks the input.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A written pixel always carries a nonzero alpha.
    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:24] != 8'd0)
        else $error("write with zero alpha");

endmodule

bind rounded_rect_over_blend_pixel rrob_checker u_rrob_checker (.*);
